// ----- hw/rtl/tactile_slip_release_detector_unit_assert.svh -----
`ifndef TACTILE_SLIP_RELEASE_DETECTOR_UNIT_ASSERT_SVH
`define TACTILE_SLIP_RELEASE_DETECTOR_UNIT_ASSERT_SVH
// Assertion helpers for the block's modules; the emitter includes them.
// Same-cycle implication, checked outside reset.
`define TSRD_AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset.
`define TSRD_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- hw/rtl/tsrd_pkg.sv -----
`timescale 1ns / 1ps
package tsrd_pkg;

    // Fixed sizes of the hand.
    localparam int FINGERS = 5;
    localparam int SLOTS   = 3;

    // Joint step of 0.1 rad in Q3.12.
    localparam logic signed [16:0] STEP_Q12 = 17'sd410;

    // Transaction commands.
    localparam logic [1:0] CMD_FORCE = 2'd0;
    localparam logic [1:0] CMD_JOINT = 2'd1;
    localparam logic [1:0] CMD_GRASP = 2'd2;

    // Grasp states with special meaning.
    localparam logic [2:0] GS_GRASPING  = 3'd1;
    localparam logic [2:0] GS_HOLDING   = 3'd2;
    localparam logic [2:0] GS_RELEASING = 3'd3;

    // Contact regions.
    localparam logic [2:0] RG_UP    = 3'd1;
    localparam logic [2:0] RG_DOWN  = 3'd2;
    localparam logic [2:0] RG_LEFT  = 3'd3;
    localparam logic [2:0] RG_RIGHT = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] REG_MIN_FORCE  = 3'd0;
    localparam logic [2:0] REG_DELTA      = 3'd1;
    localparam logic [2:0] REG_VARIATION  = 3'd2;
    localparam logic [2:0] REG_COOLDOWN   = 3'd3;
    localparam logic [2:0] REG_STARTUP    = 3'd4;
    localparam logic [2:0] REG_POST_GRASP = 3'd5;
    localparam logic [2:0] REG_LOWER      = 3'd6;
    localparam logic [2:0] REG_UPPER      = 3'd7;

    typedef struct packed {
        logic [1:0]         command;
        logic [2:0]         finger;
        logic [3:0]         region;
        logic signed [15:0] force_req;
        logic [4:0]         joint_number;
        logic signed [15:0] joint_position;
        logic [2:0]         grasp_mode;
    } t_in;

    typedef struct packed {
        logic [4:0]         joint_number_res;
        logic signed [15:0] target_position;
        logic               last;
    } t_out;

    // Pending release region per finger, zero when none.
    typedef logic [FINGERS-1:0][2:0] t_pend;

    // Window store and statistics controls.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic acc_en;
        logic acc_first;
    } t_wctl;

    // Does slot s of finger f carry a target for region r?
    function automatic logic slot_ok(input logic [2:0] f, input logic [1:0] s,
                                     input logic [2:0] r);
        logic ok;
        ok = 1'b0;
        if (r == RG_UP || r == RG_DOWN) begin
            ok = (f == 3'd0) ? (s < 2'd2) : (s < 2'd3);
        end else if (r == RG_LEFT || r == RG_RIGHT) begin
            ok = (s == 2'd0);
        end
        return ok;
    endfunction

    // Joint moved by slot s of finger f for region r.
    function automatic logic [4:0] slot_joint(input logic [2:0] f, input logic [1:0] s,
                                              input logic [2:0] r);
        logic [4:0] base;
        logic [4:0] side;
        case (f)
            3'd0: begin base = 5'd3;  side = 5'd2;  end
            3'd1: begin base = 5'd6;  side = 5'd5;  end
            3'd2: begin base = 5'd10; side = 5'd9;  end
            3'd3: begin base = 5'd14; side = 5'd13; end
            3'd4: begin base = 5'd18; side = 5'd17; end
            default: begin base = 5'd0; side = 5'd0; end
        endcase
        if (r == RG_UP || r == RG_DOWN) begin
            return base + {3'd0, s};
        end
        return side;
    endfunction

endpackage

// ----- hw/rtl/tsrd_wstat.sv -----
`timescale 1ns / 1ps
module tsrd_wstat #(
    parameter int WIN_LEN = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tsrd_pkg::t_wctl      i_ctl,
    input  logic [$clog2(tsrd_pkg::FINGERS*WIN_LEN)-1:0] i_wr_addr,
    input  logic [$clog2(tsrd_pkg::FINGERS*WIN_LEN)-1:0] i_rd_addr,
    input  logic signed [15:0]   i_force,
    input  logic signed [15:0]   i_min_force,
    input  logic signed [15:0]   i_delta,
    input  logic signed [15:0]   i_variation,
    output logic                 o_pass
);
    import tsrd_pkg::*;

    localparam int DEPTH = FINGERS * WIN_LEN;
    localparam int DW    = 16 + $clog2(WIN_LEN) + 4;
    localparam logic signed [DW-1:0] HL = DW'(WIN_LEN);

    logic signed [15:0]   r_mem [DEPTH];
    logic signed [15:0]   r_rd_data;
    logic signed [DW-1:0] r_sum;
    logic signed [15:0]   r_max;
    logic signed [15:0]   r_min;
    logic signed [DW-1:0] w_force;
    logic signed [DW-1:0] w_lhs;
    logic signed [DW-1:0] w_rhs;
    logic signed [16:0]   w_span;

    // Window store: one write and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_force;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Shared accumulator: sum, maximum and minimum, one entry a cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_max <= '0;
            r_min <= '0;
        end else if (i_ctl.acc_en) begin
            if (i_ctl.acc_first) begin
                r_sum <= DW'(r_rd_data);
                r_max <= r_rd_data;
                r_min <= r_rd_data;
            end else begin
                r_sum <= r_sum + DW'(r_rd_data);
                if (r_rd_data > r_max) begin
                    r_max <= r_rd_data;
                end
                if (r_rd_data < r_min) begin
                    r_min <= r_rd_data;
                end
            end
        end
    end

    // Trigger test on the finished window, mean compared without a divide.
    always_comb begin
        w_force = DW'(i_force);
        w_lhs   = DW'(w_force * HL) - r_sum;
        w_rhs   = DW'(DW'(i_delta) * HL);
        w_span  = 17'(r_max) - 17'(r_min);
        o_pass  = (i_force > i_min_force) && (w_lhs > w_rhs) && (w_span > 17'(i_variation));
    end

endmodule

// ----- hw/rtl/tsrd_emit.sv -----
`timescale 1ns / 1ps
`include "tactile_slip_release_detector_unit_assert.svh"
module tsrd_emit #(
    parameter int JOINT_SLOTS = 21
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  tsrd_pkg::t_pend                    i_pend,
    input  logic [JOINT_SLOTS-1:0]             i_known,
    input  logic                               i_jwr_en,
    input  logic [$clog2(JOINT_SLOTS)-1:0]     i_jwr_addr,
    input  logic signed [15:0]                 i_jwr_data,
    input  logic signed [15:0]                 i_lower,
    input  logic signed [15:0]                 i_upper,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output tsrd_pkg::t_out                     o_out_data,
    output logic                               o_done
);
    import tsrd_pkg::*;

    localparam int JW = $clog2(JOINT_SLOTS);

    localparam logic [2:0] E_IDLE = 3'd0;
    localparam logic [2:0] E_SCAN = 3'd1;
    localparam logic [2:0] E_ADD  = 3'd2;
    localparam logic [2:0] E_OUT  = 3'd3;

    logic [2:0]                      r_state;
    logic [2:0]                      r_f;
    logic [1:0]                      r_s;
    t_pend                           r_pend;
    logic [FINGERS-1:0][SLOTS-1:0]   r_mask;
    logic signed [15:0]              r_mem [JOINT_SLOTS];
    logic signed [15:0]              r_jdata;
    logic                            r_oval;
    t_out                            r_out;
    logic                            r_done;
    logic [FINGERS-1:0][SLOTS-1:0]   w_mask;
    logic                            w_later;
    logic [2:0]                      w_reg;
    logic [4:0]                      w_joint;
    logic                            w_end;
    logic                            w_rd_en;
    logic signed [16:0]              w_sum;
    logic signed [16:0]              w_t;

    // Slots that will really emit: region set and joint position known.
    always_comb begin
        for (int f = 0; f < FINGERS; f++) begin
            for (int s = 0; s < SLOTS; s++) begin
                w_mask[f][s] = slot_ok(3'(f), 2'(s), i_pend[f]) &&
                    i_known[JW'(slot_joint(3'(f), 2'(s), i_pend[f]))];
            end
        end
    end

    // Any emitting slot after the current one decides the last flag.
    always_comb begin
        w_later = 1'b0;
        for (int f = 0; f < FINGERS; f++) begin
            for (int s = 0; s < SLOTS; s++) begin
                if (r_mask[f][s] && ((3'(f) > r_f) || ((3'(f) == r_f) && (2'(s) > r_s)))) begin
                    w_later = 1'b1;
                end
            end
        end
    end

    // Shared adder and clamp; the upper limit wins over the lower.
    always_comb begin
        w_reg   = r_pend[r_f];
        w_joint = slot_joint(r_f, r_s, w_reg);
        w_end   = (r_f == 3'(FINGERS - 1)) && (r_s == 2'(SLOTS - 1));
        w_rd_en = (r_state == E_SCAN) && r_mask[r_f][r_s];
        if (w_reg == RG_UP || w_reg == RG_RIGHT) begin
            w_sum = 17'(r_jdata) - STEP_Q12;
        end else begin
            w_sum = 17'(r_jdata) + STEP_Q12;
        end
        w_t = w_sum;
        if (w_t < 17'(i_lower)) begin
            w_t = 17'(i_lower);
        end
        if (w_t > 17'(i_upper)) begin
            w_t = 17'(i_upper);
        end
    end

    // Joint position store with registered read.
    always_ff @(posedge i_clk) begin
        if (i_jwr_en) begin
            r_mem[i_jwr_addr] <= i_jwr_data;
        end
        if (w_rd_en) begin
            r_jdata <= r_mem[JW'(w_joint)];
        end
    end

    // Slot sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_f     <= '0;
            r_s     <= '0;
            r_pend  <= '0;
            r_mask  <= '0;
            r_oval  <= 1'b0;
            r_out   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                E_IDLE: begin
                    if (i_start) begin
                        r_pend  <= i_pend;
                        r_mask  <= w_mask;
                        r_f     <= '0;
                        r_s     <= '0;
                        r_state <= E_SCAN;
                    end
                end
                E_SCAN: begin
                    if (r_mask[r_f][r_s]) begin
                        r_state <= E_ADD;
                    end else if (w_end) begin
                        r_done  <= 1'b1;
                        r_state <= E_IDLE;
                    end else if (r_s == 2'(SLOTS - 1)) begin
                        r_s <= '0;
                        r_f <= r_f + 3'd1;
                    end else begin
                        r_s <= r_s + 2'd1;
                    end
                end
                E_ADD: begin
                    r_out.joint_number_res <= w_joint;
                    r_out.target_position  <= w_t[15:0];
                    r_out.last             <= !w_later;
                    r_oval                 <= 1'b1;
                    r_state                <= E_OUT;
                end
                E_OUT: begin
                    if (!i_out_stall) begin
                        r_oval <= 1'b0;
                        if (w_end) begin
                            r_done  <= 1'b1;
                            r_state <= E_IDLE;
                        end else begin
                            r_state <= E_SCAN;
                            if (r_s == 2'(SLOTS - 1)) begin
                                r_s <= '0;
                                r_f <= r_f + 3'd1;
                            end else begin
                                r_s <= r_s + 2'd1;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= E_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_oval;
    assign o_out_data  = r_out;
    assign o_done      = r_done;

    `TSRD_AST_IMP(a_out_known, o_out_valid, i_known[JW'(o_out_data.joint_number_res)], "target for an unknown joint")
    `TSRD_AST_IMP(a_done_quiet, r_done, !o_out_valid, "done while a target is still offered")
    `TSRD_AST_NXT(a_last_ends, o_out_valid && !i_out_stall && o_out_data.last, !o_out_valid, "target after the last one")
    `TSRD_AST_IMP(a_slot_range, r_state != E_IDLE, (r_f < 3'(FINGERS)) && (r_s < 2'(SLOTS)), "slot counter out of range")

endmodule

// ----- hw/rtl/tactile_slip_release_detector_unit.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Payload  Handshake
// in        input      t_in     i_in_valid / o_in_stall
// out       output     t_out    o_out_valid / i_out_stall
// cfg       input      16 bit   i_cfg_we, i_cfg_index
//
// Joint and grasp transactions are taken in the idle state. A force sample
// passes the update and finish states, and the scan and evaluate states too
// when its window is evaluated, as the window is read back one entry a cycle
// through the single statistics accumulator. On finger 4 the emitter then walks
// 15 slots, passing each target through the shared adder and clamp.
// Synchronous active-low reset restores the register defaults; output stalls
// hold the emitter, and input is stalled whenever the sequencer is busy.
module tactile_slip_release_detector_unit #(
    parameter int WIN_LEN     = 3,
    parameter int JOINT_SLOTS = 21
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  tsrd_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output tsrd_pkg::t_out   o_out_data,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data
);
    import tsrd_pkg::*;

    localparam int FILL_W = $clog2(WIN_LEN + 1);
    localparam int PTR_W  = $clog2(WIN_LEN);
    localparam int AW     = $clog2(FINGERS * WIN_LEN);
    localparam int JW     = $clog2(JOINT_SLOTS);
    localparam logic [FILL_W-1:0] HL_F = FILL_W'(WIN_LEN);
    localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(WIN_LEN - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_EVAL = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    // Configuration registers.
    logic signed [15:0] r_min_force;
    logic signed [15:0] r_delta;
    logic signed [15:0] r_variation;
    logic [7:0]         r_cool_steps;
    logic [15:0]        r_startup;
    logic [15:0]        r_post_steps;
    logic signed [15:0] r_lower;
    logic signed [15:0] r_upper;

    // Sequencer and per-finger state.
    logic [2:0]          r_state;
    logic [2:0]          r_f;
    logic [2:0]          r_region;
    logic signed [15:0]  r_force;
    logic [AW-1:0]       r_base;
    logic [FILL_W-1:0]   r_cnt;
    logic [FILL_W-1:0]   r_fill [FINGERS];
    logic [PTR_W-1:0]    r_ptr  [FINGERS];
    logic [7:0]          r_cool [FINGERS];
    t_pend               r_pend;
    logic [15:0]         r_frames;
    logic [15:0]         r_post;
    logic [2:0]          r_grasp;
    logic                r_dropped;
    logic [JOINT_SLOTS-1:0] r_known;
    logic                r_emit_start;

    logic                w_accept;
    logic                w_jwr_en;
    logic                w_drop_now;
    logic                w_gate;
    logic [FILL_W-1:0]   w_fill;
    logic [AW-1:0]       w_wr_addr;
    logic [AW-1:0]       w_rd_addr;
    t_wctl               w_ctl;
    logic                w_pass;
    logic                w_done;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_jwr_en   = w_accept && (i_in_data.command == CMD_JOINT) &&
                        ({1'b0, i_in_data.joint_number} < 6'(JOINT_SLOTS));
    assign w_drop_now = (r_grasp == GS_GRASPING) || (r_grasp == GS_RELEASING) ||
                        (r_post != 16'd0);

    // Window addressing, update gate and statistics controls.
    always_comb begin
        w_fill = r_fill[r_f];
        if (w_fill < HL_F) begin
            w_wr_addr = r_base + AW'(w_fill);
        end else begin
            w_wr_addr = r_base + AW'(r_ptr[r_f]);
        end
        w_rd_addr = r_base + AW'(r_cnt);
        w_gate = (r_frames >= r_startup) && (w_fill >= HL_F - 1'b1) &&
                 (r_cool[r_f] <= 8'd1) && (r_region >= RG_UP) && (r_region <= RG_RIGHT);
        w_ctl.wr_en     = (r_state == ST_UPD);
        w_ctl.rd_en     = (r_state == ST_SCAN) && (r_cnt < HL_F);
        w_ctl.acc_en    = (r_state == ST_SCAN) && (r_cnt != '0);
        w_ctl.acc_first = (r_state == ST_SCAN) && (r_cnt == FILL_W'(1));
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_force  <= 16'sd256;
            r_delta      <= 16'sd512;
            r_variation  <= 16'sd256;
            r_cool_steps <= 8'd5;
            r_startup    <= 16'd20;
            r_post_steps <= 16'd50;
            r_lower      <= -16'sd6144;
            r_upper      <= 16'sd6144;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MIN_FORCE:  r_min_force  <= i_cfg_data;
                REG_DELTA:      r_delta      <= i_cfg_data;
                REG_VARIATION:  r_variation  <= i_cfg_data;
                REG_COOLDOWN:   r_cool_steps <= i_cfg_data[7:0];
                REG_STARTUP:    r_startup    <= i_cfg_data;
                REG_POST_GRASP: r_post_steps <= i_cfg_data;
                REG_LOWER:      r_lower      <= i_cfg_data;
                REG_UPPER:      r_upper      <= i_cfg_data;
                default:        r_upper      <= r_upper;
            endcase
        end
    end

    // Transaction sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_f          <= '0;
            r_region     <= '0;
            r_force      <= '0;
            r_base       <= '0;
            r_cnt        <= '0;
            r_pend       <= '0;
            r_frames     <= '0;
            r_post       <= '0;
            r_grasp      <= '0;
            r_dropped    <= 1'b0;
            r_known      <= '0;
            r_emit_start <= 1'b0;
            for (int i = 0; i < FINGERS; i++) begin
                r_fill[i] <= '0;
                r_ptr[i]  <= '0;
                r_cool[i] <= '0;
            end
        end else begin
            r_emit_start <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        case (i_in_data.command)
                            CMD_JOINT: begin
                                if (w_jwr_en) begin
                                    r_known[JW'(i_in_data.joint_number)] <= 1'b1;
                                end
                            end
                            CMD_GRASP: begin
                                r_grasp <= i_in_data.grasp_mode;
                                if (r_grasp == GS_GRASPING && i_in_data.grasp_mode == GS_HOLDING) begin
                                    r_post <= r_post_steps;
                                end
                                for (int i = 0; i < FINGERS; i++) begin
                                    r_fill[i] <= '0;
                                end
                            end
                            CMD_FORCE: begin
                                if (i_in_data.finger < 3'(FINGERS)) begin
                                    r_f      <= i_in_data.finger;
                                    r_region <= (i_in_data.region[3:2] == 2'b00 ||
                                                 i_in_data.region == 4'd4) ?
                                                i_in_data.region[2:0] : 3'd0;
                                    r_force  <= i_in_data.force_req;
                                    r_base   <= AW'(i_in_data.finger * WIN_LEN);
                                    if (i_in_data.finger == 3'd0) begin
                                        // Frame opening.
                                        r_pend    <= '0;
                                        r_dropped <= w_drop_now;
                                        if (r_grasp != GS_GRASPING && r_grasp != GS_RELEASING &&
                                            r_post != 16'd0) begin
                                            r_post <= r_post - 16'd1;
                                        end
                                        if (!w_drop_now && r_frames != 16'hFFFF) begin
                                            r_frames <= r_frames + 16'd1;
                                        end
                                        if (!w_drop_now) begin
                                            r_state <= ST_UPD;
                                        end
                                    end else if (!r_dropped) begin
                                        r_state <= ST_UPD;
                                    end
                                end
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_UPD: begin
                    // Window write, fill and cooldown advance.
                    if (w_fill < HL_F) begin
                        r_fill[r_f] <= w_fill + 1'b1;
                        if (w_fill == HL_F - 1'b1) begin
                            r_ptr[r_f] <= '0;
                        end
                    end else if (r_ptr[r_f] == LAST_PTR) begin
                        r_ptr[r_f] <= '0;
                    end else begin
                        r_ptr[r_f] <= r_ptr[r_f] + 1'b1;
                    end
                    if (r_cool[r_f] != 8'd0) begin
                        r_cool[r_f] <= r_cool[r_f] - 8'd1;
                    end
                    r_cnt   <= '0;
                    r_state <= w_gate ? ST_SCAN : ST_FIN;
                end
                ST_SCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == HL_F) begin
                        r_state <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    if (w_pass) begin
                        r_pend[r_f] <= r_region;
                        r_cool[r_f] <= r_cool_steps;
                    end
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (r_f == 3'(FINGERS - 1)) begin
                        r_emit_start <= 1'b1;
                        r_state      <= ST_EMIT;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    // The emitter has taken the pending regions; clear them once it ends.
                    if (w_done) begin
                        r_pend  <= '0;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    tsrd_wstat #(
        .WIN_LEN     (WIN_LEN)
    ) u_wstat (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_wr_addr   (w_wr_addr),
        .i_rd_addr   (w_rd_addr),
        .i_force     (r_force),
        .i_min_force (r_min_force),
        .i_delta     (r_delta),
        .i_variation (r_variation),
        .o_pass      (w_pass)
    );

    tsrd_emit #(
        .JOINT_SLOTS (JOINT_SLOTS)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_emit_start),
        .i_pend      (r_pend),
        .i_known     (r_known),
        .i_jwr_en    (w_jwr_en),
        .i_jwr_addr  (JW'(i_in_data.joint_number)),
        .i_jwr_data  (i_in_data.joint_position),
        .i_lower     (r_lower),
        .i_upper     (r_upper),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_done      (w_done)
    );

endmodule
